// ----- rtl/hrhe_pkg.sv -----
// Shared types, constants and lookup functions for the HTTP request host extractor.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none
package hrhe_pkg;

   // Response kinds
   localparam logic [1:0] KIND_HOST_BYTE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT    = 2'd1;
   localparam logic [1:0] KIND_REJECT    = 2'd2;
   localparam logic [1:0] KIND_FINISHED  = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_SP = 8'h20;

   // Queue between parser and output stage; the depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int NUM_METHODS = 16;

   // Method names, right-justified in 72 bits, and their lengths.
   localparam logic [71:0] METHOD_TEXT [NUM_METHODS] = '{
      "OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE", "CONNECT",
      "PATCH", "PROPFIND", "PROPPATCH", "MKCOL", "COPY", "MOVE", "LOCK", "UNLOCK"
   };
   localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
      4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7,
      4'd5, 4'd8, 4'd9, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6
   };

   // One queued entry: an optional host byte or marker, then an optional finish.
   typedef struct packed {
      logic        has_first;
      logic [1:0]  first_kind;
      logic [7:0]  first_byte;
      logic        has_fin;
      logic [15:0] count;
   } entry_type;

   // Character of method m at position pos; zero beyond the end of the name.
   function automatic logic [7:0] method_char(input logic [3:0] m, input logic [3:0] pos);
      logic [71:0] txt;
      logic [3:0]  len;
      logic [3:0]  sh;
      begin
         txt = METHOD_TEXT[m];
         len = METHOD_LEN[m];
         sh  = len - 4'd1 - pos;
         if (pos >= len) begin
            return 8'h00;
         end
         return txt[{sh, 3'b000} +: 8];
      end
   endfunction

   // Expected byte of the protocol tail "HTTP/1.x" CR LF; the version digit is checked apart.
   function automatic logic [7:0] tail_char(input logic [3:0] pos);
      begin
         case (pos)
            4'd0:    return "H";
            4'd1:    return "T";
            4'd2:    return "T";
            4'd3:    return "P";
            4'd4:    return "/";
            4'd5:    return "1";
            4'd6:    return ".";
            4'd8:    return CH_CR;
            4'd9:    return CH_LF;
            default: return 8'h00;
         endcase
      end
   endfunction

   // Lower-case text of the header name "host:".
   function automatic logic [7:0] host_char(input logic [3:0] pos);
      begin
         case (pos)
            4'd0:    return "h";
            4'd1:    return "o";
            4'd2:    return "s";
            4'd3:    return "t";
            4'd4:    return ":";
            default: return 8'h00;
         endcase
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/hrhe_front.sv -----
// Parser front end: accepts payload bytes, checks the request line, scans header lines.
// Produces queue entries of type hrhe_pkg::entry_type; depends on hrhe_pkg.
`default_nettype none
module hrhe_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_payload,
   input  wire logic                  q_full,
   output logic                       push,
   output hrhe_pkg::entry_type        push_entry
);

   localparam logic [1:0] PH_REQ  = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;
   localparam logic [1:0] PH_FAIL = 2'd3;

   localparam logic [1:0] RP_METHOD    = 2'd0;
   localparam logic [1:0] RP_URI_FIRST = 2'd1;
   localparam logic [1:0] RP_URI       = 2'd2;
   localparam logic [1:0] RP_TAIL      = 2'd3;

   localparam logic [3:0] HS_NAME_END = 4'd5;
   localparam logic [3:0] HS_LEAD     = 4'd5;
   localparam logic [3:0] HS_CAP      = 4'd6;
   localparam logic [3:0] HS_TRAIL    = 4'd7;
   localparam logic [3:0] HS_TRAIL_CR = 4'd8;
   localparam logic [3:0] HS_SKIP     = 4'd9;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  rl_part_ff, rl_part_in;
   logic [3:0]  rl_step_ff, rl_step_in;
   logic [15:0] alive_ff, alive_in;
   logic [3:0]  hl_step_ff, hl_step_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        prev_cr_ff, prev_cr_in;
   logic [1:0]  lines_ff, lines_in;
   logic        host_sent_ff, host_sent_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] committed_ff, committed_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  low;
   logic        eol;
   logic [15:0] seen_inc;
   logic [15:0] keep;
   hrhe_pkg::entry_type ent;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data_byte;
   assign low       = (b inside {["A":"Z"]}) ? (b + 8'd32) : b;
   assign eol       = (b == hrhe_pkg::CH_LF) && prev_cr_ff;
   assign seen_inc  = (seen_ff == 16'hFFFF) ? seen_ff : (seen_ff + 16'd1);

   // Method match, one lane per method name.
   always_comb begin
      for (int k = 0; k < hrhe_pkg::NUM_METHODS; k++) begin
         if (b == hrhe_pkg::CH_SP) begin
            keep[k] = alive_ff[k] && (hrhe_pkg::METHOD_LEN[k] == rl_step_ff);
         end else begin
            keep[k] = alive_ff[k] && (hrhe_pkg::METHOD_LEN[k] > rl_step_ff) &&
                      (hrhe_pkg::method_char(4'(k), rl_step_ff) == b);
         end
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      rl_part_in    = rl_part_ff;
      rl_step_in    = rl_step_ff;
      alive_in      = alive_ff;
      hl_step_in    = hl_step_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      prev_cr_in    = prev_cr_ff;
      lines_in      = lines_ff;
      host_sent_in  = host_sent_ff;
      seen_in       = seen_ff;
      committed_in  = committed_ff;
      ent           = '0;

      if (accept) begin
         seen_in    = seen_inc;
         prev_cr_in = (b == hrhe_pkg::CH_CR);
         case (phase_ff)
            PH_REQ: begin
               case (rl_part_ff)
                  RP_METHOD: begin
                     if (keep == 16'd0) begin
                        phase_in = PH_FAIL;
                     end else if (b == hrhe_pkg::CH_SP) begin
                        rl_part_in = RP_URI_FIRST;
                        rl_step_in = 4'd0;
                     end else begin
                        alive_in   = keep;
                        rl_step_in = rl_step_ff + 4'd1;
                     end
                  end
                  RP_URI_FIRST: begin
                     if (b == hrhe_pkg::CH_SP) begin
                        phase_in = PH_FAIL;
                     end else begin
                        rl_part_in = RP_URI;
                     end
                  end
                  RP_URI: begin
                     if (b == hrhe_pkg::CH_SP) begin
                        rl_part_in = RP_TAIL;
                        rl_step_in = 4'd0;
                     end
                  end
                  default: begin
                     if ((rl_step_ff > 4'd9) ||
                         ((rl_step_ff == 4'd7) && !(b inside {"0", "1"})) ||
                         ((rl_step_ff != 4'd7) && (hrhe_pkg::tail_char(rl_step_ff) != b))) begin
                        phase_in = PH_FAIL;
                     end else if (rl_step_ff == 4'd9) begin
                        phase_in     = PH_HDR;
                        committed_in = seen_inc;
                        hl_step_in   = 4'd0;
                        lines_in     = 2'd0;
                     end else begin
                        rl_step_in = rl_step_ff + 4'd1;
                     end
                  end
               endcase
            end
            PH_HDR: begin
               if (eol && (lines_ff == 2'd1)) begin
                  committed_in = seen_inc;
                  phase_in     = PH_DONE;
               end else begin
                  if (hl_step_ff < HS_NAME_END) begin
                     hl_step_in = (low == hrhe_pkg::host_char(hl_step_ff)) ?
                                  (hl_step_ff + 4'd1) : HS_SKIP;
                  end else begin
                     case (hl_step_ff)
                        HS_LEAD: begin
                           if (b != hrhe_pkg::CH_SP) begin
                              held_byte_in  = b;
                              held_valid_in = 1'b1;
                              hl_step_in    = HS_CAP;
                           end
                        end
                        HS_CAP: begin
                           if (eol) begin
                              ent.has_first  = 1'b1;
                              ent.first_kind = host_sent_ff ? hrhe_pkg::KIND_ACCEPT
                                                            : hrhe_pkg::KIND_REJECT;
                           end else begin
                              if (held_valid_ff) begin
                                 ent.has_first  = 1'b1;
                                 ent.first_kind = hrhe_pkg::KIND_HOST_BYTE;
                                 ent.first_byte = held_byte_ff;
                                 host_sent_in   = 1'b1;
                              end
                              if (b == hrhe_pkg::CH_SP) begin
                                 held_valid_in = 1'b0;
                                 hl_step_in    = HS_TRAIL;
                              end else begin
                                 held_byte_in  = b;
                                 held_valid_in = 1'b1;
                              end
                           end
                        end
                        HS_TRAIL: begin
                           if (b == hrhe_pkg::CH_CR) begin
                              hl_step_in = HS_TRAIL_CR;
                           end else if (b != hrhe_pkg::CH_SP) begin
                              ent.has_first  = 1'b1;
                              ent.first_kind = hrhe_pkg::KIND_REJECT;
                              hl_step_in     = HS_SKIP;
                           end
                        end
                        HS_TRAIL_CR: begin
                           ent.has_first = 1'b1;
                           if (eol) begin
                              ent.first_kind = hrhe_pkg::KIND_ACCEPT;
                           end else begin
                              ent.first_kind = hrhe_pkg::KIND_REJECT;
                              hl_step_in     = HS_SKIP;
                           end
                        end
                        default: ;
                     endcase
                  end
                  if (eol) begin
                     committed_in  = seen_inc;
                     hl_step_in    = 4'd0;
                     lines_in      = 2'd0;
                     held_valid_in = 1'b0;
                     host_sent_in  = 1'b0;
                  end else if (lines_ff != 2'd2) begin
                     lines_in = lines_ff + 2'd1;
                  end
               end
            end
            default: ;
         endcase

         if (req_end_of_payload) begin
            // A host line cut off by payload end after its value began is rejected.
            if ((phase_in == PH_HDR) && (hl_step_in inside {[HS_CAP:HS_TRAIL_CR]})) begin
               ent.has_first  = 1'b1;
               ent.first_kind = hrhe_pkg::KIND_REJECT;
               ent.first_byte = 8'h00;
            end
            ent.has_fin = 1'b1;
            ent.count   = (phase_in inside {PH_HDR, PH_DONE}) ? committed_in : 16'd0;

            phase_in      = PH_REQ;
            rl_part_in    = RP_METHOD;
            rl_step_in    = 4'd0;
            alive_in      = 16'hFFFF;
            hl_step_in    = 4'd0;
            held_valid_in = 1'b0;
            prev_cr_in    = 1'b0;
            lines_in      = 2'd0;
            host_sent_in  = 1'b0;
            seen_in       = 16'd0;
            committed_in  = 16'd0;
         end
      end
   end

   assign push       = accept && (ent.has_first || ent.has_fin);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_REQ;
         rl_part_ff    <= RP_METHOD;
         rl_step_ff    <= 4'd0;
         alive_ff      <= 16'hFFFF;
         hl_step_ff    <= 4'd0;
         held_valid_ff <= 1'b0;
         prev_cr_ff    <= 1'b0;
         lines_ff      <= 2'd0;
         host_sent_ff  <= 1'b0;
         seen_ff       <= 16'd0;
         committed_ff  <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         rl_part_ff    <= rl_part_in;
         rl_step_ff    <= rl_step_in;
         alive_ff      <= alive_in;
         hl_step_ff    <= hl_step_in;
         held_valid_ff <= held_valid_in;
         prev_cr_ff    <= prev_cr_in;
         lines_ff      <= lines_in;
         host_sent_ff  <= host_sent_in;
         seen_ff       <= seen_in;
         committed_ff  <= committed_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule
`default_nettype wire

// ----- rtl/hrhe_queue.sv -----
// Short FIFO of parser results between the front end and the output stage.
// Depends on hrhe_pkg for the entry type and the queue depth.
`default_nettype none
module hrhe_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire hrhe_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output hrhe_pkg::entry_type      head
);

   hrhe_pkg::entry_type mem [hrhe_pkg::QUEUE_DEPTH];

   logic [hrhe_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hrhe_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hrhe_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push;
   logic do_pop;

   assign full      = (cnt_ff == hrhe_pkg::QUEUE_CNT_W'(hrhe_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/hrhe_back.sv -----
// Output stage: takes queue entries and presents them as one or two responses each.
// Depends on hrhe_pkg for the entry type and response kinds.
`default_nettype none
module hrhe_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                not_empty,
   input  wire hrhe_pkg::entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_host_byte,
   output logic [15:0]              rsp_processed_bytes,
   output logic                     rsp_last_of_run
);

   hrhe_pkg::entry_type cur_ff, cur_in;
   logic cur_valid_ff, cur_valid_in;
   logic second_ff, second_in;
   logic taken;

   assign taken = cur_valid_ff && !rsp_stall;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (taken && !second_ff && cur_ff.has_fin) begin
         second_in = 1'b1;
      end else if (taken || !cur_valid_ff) begin
         if (not_empty) begin
            pop          = 1'b1;
            cur_in       = head;
            cur_valid_in = 1'b1;
            second_in    = !head.has_first;
         end else begin
            cur_valid_in = 1'b0;
         end
      end
   end

   assign rsp_valid           = cur_valid_ff;
   assign rsp_kind            = second_ff ? hrhe_pkg::KIND_FINISHED : cur_ff.first_kind;
   assign rsp_host_byte       = second_ff ? 8'h00 : cur_ff.first_byte;
   assign rsp_processed_bytes = second_ff ? cur_ff.count : 16'd0;
   assign rsp_last_of_run     = second_ff || !cur_ff.has_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

// ----- rtl/http_request_host_extractor_top.sv -----
// The first response to a request is registered in the queue, then in the output stage.
// Throughput: one request per cycle while the queue is not full; the last byte of a payload
//    may give two responses, presented one after the other, which the result queue absorbs.
// Rate is set by the byte parser, which updates its state once per request.
// Reset is synchronous and active high; it clears the parser, the queue and the output stage.
`default_nettype none
module http_request_host_extractor_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_host_byte,
   output logic [15:0]      rsp_processed_bytes,
   output logic             rsp_last_of_run
);

   // The front end parses each byte as it is taken and pushes an entry whenever that
   // byte produces any response. The queue decouples it from the output stage, so a
   // stalled response side only holds off requests once the queue has filled.
   logic                q_full;
   logic                q_push;
   hrhe_pkg::entry_type q_push_entry;
   logic                q_pop;
   logic                q_not_empty;
   hrhe_pkg::entry_type q_head;

   hrhe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_payload (req_end_of_payload),
      .q_full             (q_full),
      .push               (q_push),
      .push_entry         (q_push_entry)
   );

   hrhe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // The output stage holds one entry and shows its marker or host byte first and
   // the payload-finished response second, when the entry carries both.
   hrhe_back u_back (
      .clock               (clock),
      .reset               (reset),
      .not_empty           (q_not_empty),
      .head                (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_host_byte       (rsp_host_byte),
      .rsp_processed_bytes (rsp_processed_bytes),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule
`default_nettype wire
